### sv/vba_pkg.sv
// ----------------------------------------------------------------------------
// vba_pkg - shared definitions for the vector bearing block
// Defaults, fixed widths, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package vba_pkg;

   localparam int COORD_BITS_DEF      = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STAGES_DEF   = 16;

   // angle accumulator: degrees with 16 fraction bits
   localparam int ACC_FRAC  = 16;
   localparam int ZW        = 26;               // signed accumulator width
   localparam int ZC_W      = 24;               // clamped angle, 0..180 deg
   localparam int ANG_ACC_W = ACC_FRAC + 9;     // rounded angle before masking
   localparam int ANGLE_W   = 17;
   localparam int RSP_DATA_W = ((ANGLE_W + 7) / 8) * 8;

   // vector components are brought below 2^NORM_MAG_BITS in magnitude
   localparam int NORM_MAG_BITS = 28;

   localparam int ORIGIN_X_RST     = 400;
   localparam int ORIGIN_Y_RST     = 300;
   localparam int LOOK_POINT_X_RST = 400;
   localparam int LOOK_POINT_Y_RST = 70;

   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * (1 << ACC_FRAC));
   localparam logic signed [ZW-1:0] Z_HALF    = ZW'(180 * (1 << ACC_FRAC));

   localparam int CSR_ADDR_W = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ORIGIN_X     = 2'd0,
      REG_ORIGIN_Y     = 2'd1,
      REG_LOOK_POINT_X = 2'd2,
      REG_LOOK_POINT_Y = 2'd3
   } vba_reg_type;

   // sideband that follows each request down the pipeline
   typedef struct packed {
      logic degen;   // target or look point equals origin
      logic neg;     // cross product below zero
   } vba_side_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [ZW-1:0] vba_atan(input int unsigned idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = ZW'(2949120);
         1:  v = ZW'(1740967);
         2:  v = ZW'(919879);
         3:  v = ZW'(466945);
         4:  v = ZW'(234379);
         5:  v = ZW'(117304);
         6:  v = ZW'(58666);
         7:  v = ZW'(29335);
         8:  v = ZW'(14668);
         9:  v = ZW'(7334);
         10: v = ZW'(3667);
         11: v = ZW'(1833);
         12: v = ZW'(917);
         13: v = ZW'(458);
         14: v = ZW'(229);
         15: v = ZW'(115);
         16: v = ZW'(57);
         17: v = ZW'(29);
         18: v = ZW'(14);
         19: v = ZW'(7);
         20: v = ZW'(4);
         21: v = ZW'(2);
         22: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### sv/vba_prep.sv
// ----------------------------------------------------------------------------
// vba_prep - vector setup
// Forms look and target vectors, scales large ones, and computes the dot
// and cross products over four pipeline stages.
// ----------------------------------------------------------------------------
module vba_prep import vba_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] target_x,
   input  logic signed [COORD_BITS-1:0] target_y,
   input  logic signed [COORD_BITS-1:0] origin_x,
   input  logic signed [COORD_BITS-1:0] origin_y,
   input  logic signed [COORD_BITS-1:0] look_x,
   input  logic signed [COORD_BITS-1:0] look_y,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [2*((COORD_BITS+1 < NORM_MAG_BITS+1) ? COORD_BITS+1
                          : NORM_MAG_BITS+1):0] dot,
   output logic signed [2*((COORD_BITS+1 < NORM_MAG_BITS+1) ? COORD_BITS+1
                          : NORM_MAG_BITS+1):0] cross_prod,
   output vba_side_type                 side
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = (DW < NORM_MAG_BITS + 1) ? DW : NORM_MAG_BITS + 1;
   localparam int MW = 2 * PW;
   localparam int VW = MW + 1;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

   assign s4_rdy   = !s4_v_ff || out_ready;
   assign s3_rdy   = !s3_v_ff || s4_rdy;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= in_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: difference vectors
   logic signed [DW-1:0] tx_in, ty_in, lx_in, ly_in;
   logic signed [DW-1:0] tx_ff, ty_ff, lx_ff, ly_ff;

   assign tx_in = DW'(target_x) - DW'(origin_x);
   assign ty_in = DW'(target_y) - DW'(origin_y);
   assign lx_in = DW'(look_x) - DW'(origin_x);
   assign ly_in = DW'(look_y) - DW'(origin_y);

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         lx_ff <= lx_in;
         ly_ff <= ly_in;
      end
   end

   // stage 2: zero-length check and common scaling
   logic signed [PW-1:0] ntx_in, nty_in, nlx_in, nly_in;
   logic signed [PW-1:0] ntx_ff, nty_ff, nlx_ff, nly_ff;
   logic                 degen_in, degen2_ff;

   assign degen_in = (tx_ff == '0 && ty_ff == '0) || (lx_ff == '0 && ly_ff == '0);

   if (DW > NORM_MAG_BITS) begin : g_norm
      localparam int SMAX = DW - NORM_MAG_BITS;
      localparam int SW   = $clog2(SMAX + 1);

      function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
         return v[DW-1] ? DW'(-v) : DW'(v);
      endfunction

      logic [DW-1:0] mag_or;
      logic [SW-1:0] sh;

      // shift amount follows the highest set bit of the largest magnitude
      always_comb begin
         mag_or = mag_f(tx_ff) | mag_f(ty_ff) | mag_f(lx_ff) | mag_f(ly_ff);
         sh     = '0;
         for (int k = NORM_MAG_BITS; k < DW; k++) begin
            if (mag_or[k]) sh = SW'(k - NORM_MAG_BITS + 1);
         end
      end

      assign ntx_in = PW'(tx_ff >>> sh);
      assign nty_in = PW'(ty_ff >>> sh);
      assign nlx_in = PW'(lx_ff >>> sh);
      assign nly_in = PW'(ly_ff >>> sh);
   end else begin : g_direct
      assign ntx_in = tx_ff;
      assign nty_in = ty_ff;
      assign nlx_in = lx_ff;
      assign nly_in = ly_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_v_ff) begin
         ntx_ff    <= ntx_in;
         nty_ff    <= nty_in;
         nlx_ff    <= nlx_in;
         nly_ff    <= nly_in;
         degen2_ff <= degen_in;
      end
   end

   // stage 3: four products
   logic signed [MW-1:0] p_lx_tx_in, p_ly_ty_in, p_lx_ty_in, p_ly_tx_in;
   logic signed [MW-1:0] p_lx_tx_ff, p_ly_ty_ff, p_lx_ty_ff, p_ly_tx_ff;
   logic                 degen3_ff;

   assign p_lx_tx_in = MW'(nlx_ff) * MW'(ntx_ff);
   assign p_ly_ty_in = MW'(nly_ff) * MW'(nty_ff);
   assign p_lx_ty_in = MW'(nlx_ff) * MW'(nty_ff);
   assign p_ly_tx_in = MW'(nly_ff) * MW'(ntx_ff);

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_v_ff) begin
         p_lx_tx_ff <= p_lx_tx_in;
         p_ly_ty_ff <= p_ly_ty_in;
         p_lx_ty_ff <= p_lx_ty_in;
         p_ly_tx_ff <= p_ly_tx_in;
         degen3_ff  <= degen2_ff;
      end
   end

   // stage 4: dot and cross
   logic signed [VW-1:0] dot_in, cross_in;
   logic signed [VW-1:0] dot_ff, cross_ff;
   logic                 degen4_ff;

   assign dot_in   = VW'(p_lx_tx_ff) + VW'(p_ly_ty_ff);
   assign cross_in = VW'(p_lx_ty_ff) - VW'(p_ly_tx_ff);

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_v_ff) begin
         dot_ff    <= dot_in;
         cross_ff  <= cross_in;
         degen4_ff <= degen3_ff;
      end
   end

   assign out_valid  = s4_v_ff;
   assign dot        = dot_ff;
   assign cross_prod = cross_ff;
   assign side.degen = degen4_ff;
   assign side.neg   = cross_ff[VW-1];

endmodule

### sv/vba_cordic.sv
// ----------------------------------------------------------------------------
// vba_cordic - pipelined CORDIC vectoring unit
// Takes (dot, |cross|) and accumulates the unsigned angle in degrees Q16,
// one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module vba_cordic import vba_pkg::*; #(
   parameter int COORD_BITS    = COORD_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [2*((COORD_BITS+1 < NORM_MAG_BITS+1) ? COORD_BITS+1
                          : NORM_MAG_BITS+1):0] dot,
   input  logic signed [2*((COORD_BITS+1 < NORM_MAG_BITS+1) ? COORD_BITS+1
                          : NORM_MAG_BITS+1):0] cross_prod,
   input  vba_side_type             in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [ZW-1:0]     z,
   output vba_side_type             out_side
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = (DW < NORM_MAG_BITS + 1) ? DW : NORM_MAG_BITS + 1;
   localparam int VW = 2 * PW + 1;
   localparam int CW = VW + 2;       // headroom for the CORDIC gain
   localparam int N  = CORDIC_STAGES;

   logic signed [CW-1:0] x_ff [0:N-1];
   logic signed [CW-1:0] y_ff [0:N-1];
   logic signed [ZW-1:0] z_ff [0:N];
   vba_side_type         side_ff [0:N];
   logic                 v_ff [0:N];
   logic                 rdy [0:N+1];

   assign rdy[N+1] = out_ready;

   for (genvar k = 0; k <= N; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   assign in_ready = rdy[0];

   // entry stage: fold the vector into the right half plane
   logic signed [CW-1:0] dot_w, mcross, x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;

   always_comb begin
      dot_w  = CW'(dot);
      mcross = cross_prod[VW-1] ? -CW'(cross_prod) : CW'(cross_prod);
      if (dot_w[CW-1]) begin
         x0_in = mcross;
         y0_in = -dot_w;
         z0_in = Z_QUARTER;
      end else begin
         x0_in = dot_w;
         y0_in = mcross;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      localparam int I = k - 1;

      logic signed [CW-1:0] xp, yp;
      logic signed [ZW-1:0] z_in;
      logic                 up;

      assign xp = x_ff[k-1];
      assign yp = y_ff[k-1];
      assign up = !yp[CW-1] && (yp != '0);

      assign z_in = up ? z_ff[k-1] + vba_atan(I) : z_ff[k-1] - vba_atan(I);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && v_ff[k-1]) begin
            z_ff[k]    <= z_in;
            side_ff[k] <= side_ff[k-1];
         end
      end

      if (k < N) begin : g_xy
         logic signed [CW-1:0] x_in, y_in;

         assign x_in = up ? xp + (yp >>> I) : xp - (yp >>> I);
         assign y_in = up ? yp - (xp >>> I) : yp + (xp >>> I);

         always_ff @(posedge clock) begin
            if (rdy[k] && v_ff[k-1]) begin
               x_ff[k] <= x_in;
               y_ff[k] <= y_in;
            end
         end
      end
   end

   assign out_valid = v_ff[N];
   assign z         = z_ff[N];
   assign out_side  = side_ff[N];

endmodule

### sv/vba_finish.sv
// ----------------------------------------------------------------------------
// vba_finish - angle clamp, rounding and 0..360 fold
// Two stages; the second one is the response register.
// ----------------------------------------------------------------------------
module vba_finish import vba_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [ZW-1:0] z,
   input  vba_side_type         in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [ANGLE_W-1:0]   angle_q8,
   output logic                 degenerate
);

   localparam int AW = ANG_ACC_W;

   logic f1_v_ff, f2_v_ff;
   logic f1_rdy, f2_rdy;

   assign f2_rdy   = !f2_v_ff || out_ready;
   assign f1_rdy   = !f1_v_ff || f2_rdy;
   assign in_ready = f1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         if (f1_rdy) f1_v_ff <= in_valid;
         if (f2_rdy) f2_v_ff <= f1_v_ff;
      end
   end

   // stage 1: clamp to 0..180 degrees
   logic [ZC_W-1:0] zc_in, zc_ff;
   vba_side_type    side1_ff;

   always_comb begin
      if (z[ZW-1]) begin
         zc_in = '0;
      end else if (z > Z_HALF) begin
         zc_in = ZC_W'(Z_HALF);
      end else begin
         zc_in = ZC_W'(z);
      end
   end

   always_ff @(posedge clock) begin
      if (f1_rdy && in_valid) begin
         zc_ff    <= zc_in;
         side1_ff <= in_side;
      end
   end

   // stage 2: round half up, mirror for negative cross, zero when degenerate
   logic [AW-1:0] a_rnd, a_fold, full;
   logic [ANGLE_W-1:0] angle_in, angle_ff;
   logic               degen_ff;

   if (ANGLE_FRAC_BITS < ACC_FRAC) begin : g_round
      localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
      assign a_rnd = (AW'(zc_ff) + (AW'(1) << (SH - 1))) >> SH;
   end else begin : g_exact
      assign a_rnd = AW'(zc_ff);
   end

   assign full = AW'(360) << ANGLE_FRAC_BITS;

   always_comb begin
      a_fold = a_rnd;
      if (side1_ff.neg && a_rnd != '0) a_fold = full - a_rnd;
      if (a_fold >= full) a_fold = '0;
      if (side1_ff.degen) a_fold = '0;
      angle_in = a_fold[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (f2_rdy && f1_v_ff) begin
         angle_ff <= angle_in;
         degen_ff <= side1_ff.degen;
      end
   end

   assign out_valid  = f2_v_ff;
   assign angle_q8   = angle_ff;
   assign degenerate = degen_ff;

endmodule

### sv/vector_bearing_angle_0_360_top.sv
// ----------------------------------------------------------------------------
// vector_bearing_angle_0_360_top - bearing of a target from a look direction
//
//   channel  dir  handshake          payload
//   req      in   req_tvalid/tready  tdata: target_x, target_y
//   rsp      out  rsp_tvalid/tready  tdata: angle_q8; tuser: degenerate
//   csr      in   csr_wr_en          csr_addr, csr_wdata (no read-back)
//
// One request per cycle sustained while rsp_tready is high. Stages in order:
// four setup stages (vectors, scaling, products, dot/cross), the CORDIC
// entry stage, one stage per micro-rotation and two finishing stages.
// Every stage has its own valid bit and ready term, so bubbles collapse
// and a stalled response holds without dropping or repeating a request.
// Synchronous reset clears the valid bits and loads the default points.
// ----------------------------------------------------------------------------
module vector_bearing_angle_0_360_top import vba_pkg::*; #(
   parameter int COORD_BITS      = COORD_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]   req_tdata,   // target_x, target_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_W-1:0]               rsp_tdata,   // angle_q8
   output logic                                rsp_tuser,   // degenerate
   input  logic                                csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]               csr_addr,
   input  logic [COORD_BITS-1:0]               csr_wdata
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = (DW < NORM_MAG_BITS + 1) ? DW : NORM_MAG_BITS + 1;
   localparam int VW = 2 * PW + 1;

   // configuration registers
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_y_ff, look_x_ff, look_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= COORD_BITS'(ORIGIN_X_RST);
         origin_y_ff <= COORD_BITS'(ORIGIN_Y_RST);
         look_x_ff   <= COORD_BITS'(LOOK_POINT_X_RST);
         look_y_ff   <= COORD_BITS'(LOOK_POINT_Y_RST);
      end else if (csr_wr_en) begin
         unique case (vba_reg_type'(csr_addr))
            REG_ORIGIN_X:     origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y:     origin_y_ff <= csr_wdata;
            REG_LOOK_POINT_X: look_x_ff   <= csr_wdata;
            REG_LOOK_POINT_Y: look_y_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [COORD_BITS-1:0] target_x, target_y;

   assign target_x = req_tdata[COORD_BITS-1:0];
   assign target_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   logic                 prep_valid, prep_ready;
   logic signed [VW-1:0] dot, cross_prod;
   vba_side_type         prep_side;

   vba_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .target_x   (target_x),
      .target_y   (target_y),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .look_x     (look_x_ff),
      .look_y     (look_y_ff),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .dot        (dot),
      .cross_prod (cross_prod),
      .side       (prep_side)
   );

   logic                 cor_valid, cor_ready;
   logic signed [ZW-1:0] cor_z;
   vba_side_type         cor_side;

   vba_cordic #(
      .COORD_BITS    (COORD_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_ready   (prep_ready),
      .dot        (dot),
      .cross_prod (cross_prod),
      .in_side    (prep_side),
      .out_valid  (cor_valid),
      .out_ready  (cor_ready),
      .z          (cor_z),
      .out_side   (cor_side)
   );

   logic [ANGLE_W-1:0] angle_q8;

   vba_finish #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cor_valid),
      .in_ready   (cor_ready),
      .z          (cor_z),
      .in_side    (cor_side),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .angle_q8   (angle_q8),
      .degenerate (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(angle_q8);

endmodule
